>>> sv/hrfp_pkg.sv
// HTTP request framing parser: shared types, constants and character lookups.
// Used by the top level, the port checker and the testbench checker.
// No dependencies.
`default_nettype none

package hrfp_pkg;

   // Parse phase, one-hot
   typedef enum logic [2:0] {
      PH_LINE = 3'b001,
      PH_HDR  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   // Status codes on the final transaction
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_NO_TERM    = 4'd1;
   localparam logic [3:0] ST_NO_LINE    = 4'd2;
   localparam logic [3:0] ST_BAD_LINE   = 4'd3;
   localparam logic [3:0] ST_VERSION    = 4'd4;
   localparam logic [3:0] ST_HEADER     = 4'd5;
   localparam logic [3:0] ST_BAD_LENGTH = 4'd6;
   localparam logic [3:0] ST_TOO_LARGE  = 4'd7;
   localparam logic [3:0] ST_FRAMING    = 4'd8;
   localparam logic [3:0] ST_INCOMPLETE = 4'd9;

   // Byte kinds
   localparam logic [1:0] KIND_METHOD = 2'd0;
   localparam logic [1:0] KIND_PATH   = 2'd1;
   localparam logic [1:0] KIND_BODY   = 2'd2;

   // Header value trimming
   localparam logic [1:0] TRIM_LEAD   = 2'd0;
   localparam logic [1:0] TRIM_DIGITS = 2'd1;
   localparam logic [1:0] TRIM_TAIL   = 2'd2;

   // Characters
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Match strings, first character in the top byte
   localparam int CL_BYTES  = 14;
   localparam int TE_BYTES  = 17;
   localparam int VER_BYTES = 8;
   localparam logic [8*CL_BYTES-1:0]  CL_NAME  = "content-length";
   localparam logic [8*TE_BYTES-1:0]  TE_NAME  = "transfer-encoding";
   localparam logic [8*VER_BYTES-1:0] VER_TEXT = "HTTP/1.1";

   localparam logic [4:0]  CL_LEN       = 5'(CL_BYTES);
   localparam logic [4:0]  TE_LEN       = 5'(TE_BYTES);
   localparam logic [3:0]  VER_LEN      = 4'(VER_BYTES);
   localparam logic [4:0]  NAME_IDX_MAX = 5'd31;
   localparam logic [17:0] POS_MAX      = 18'h3FFFF;

   localparam logic [16:0] MAX_MESSAGE_RESET = 17'd65536;

   // Parser state
   typedef struct packed {
      phase_type   phase;
      logic        pend_cr;
      logic        line_nz;      // current line holds at least one byte
      logic [1:0]  space_cnt;
      logic [3:0]  ver_idx;
      logic        ver_bad;
      logic [4:0]  name_idx;
      logic [1:0]  name_match;   // bit 0 content-length, bit 1 transfer-encoding
      logic        colon_seen;
      logic [1:0]  trim;
      logic        value_bad;
      logic [63:0] acc;
      logic        acc_ovf;
      logic        length_seen;
      logic [16:0] body_len;
      logic [17:0] byte_pos;
      logic [16:0] body_rem;
      logic        term_seen;
      logic [3:0]  err;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_LINE,
      pend_cr:     1'b0,
      line_nz:     1'b0,
      space_cnt:   2'd0,
      ver_idx:     4'd0,
      ver_bad:     1'b0,
      name_idx:    5'd0,
      name_match:  2'b11,
      colon_seen:  1'b0,
      trim:        TRIM_LEAD,
      value_bad:   1'b0,
      acc:         64'd0,
      acc_ovf:     1'b0,
      length_seen: 1'b0,
      body_len:    17'd0,
      byte_pos:    18'd0,
      body_rem:    17'd0,
      term_seen:   1'b0,
      err:         ST_OK
   };

   // Outcome of one content byte
   typedef struct packed {
      state_type  st;
      logic       emit;
      logic [1:0] kind;
   } content_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] byte_kind;
      logic       is_status;
      logic [3:0] status_code;
      logic       last;
   } rsp_item_type;

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      logic [7:0] c;
      c = 8'h00;
      if (i < CL_LEN) c = CL_NAME[8 * (CL_BYTES - 1 - int'(i)) +: 8];
      return c;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      logic [7:0] c;
      c = 8'h00;
      if (i < TE_LEN) c = TE_NAME[8 * (TE_BYTES - 1 - int'(i)) +: 8];
      return c;
   endfunction

   function automatic logic [7:0] ver_char(input logic [3:0] i);
      logic [7:0] c;
      c = 8'h00;
      if (i < VER_LEN) c = VER_TEXT[8 * (VER_BYTES - 1 - int'(i)) +: 8];
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/hrfp_channels.sv
// Valid/ready channel interfaces: request bytes, results and register writes.
// Plain wiring bundles; no dependencies.
`default_nettype none

interface hrfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;
   modport source (output valid, in_byte, end_of_message, input ready);
   modport sink   (input valid, in_byte, end_of_message, output ready);
endinterface

interface hrfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] byte_kind;
   logic       is_status;
   logic [3:0] status_code;
   logic       last;
   modport source (output valid, out_byte, byte_kind, is_status, status_code, last,
                   input ready);
   modport sink   (input valid, out_byte, byte_kind, is_status, status_code, last,
                   output ready);
endinterface

interface hrfp_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] max_message_bytes;
   modport source (output valid, max_message_bytes, input ready);
   modport sink   (input valid, max_message_bytes, output ready);
endinterface

`default_nettype wire

>>> sv/http_request_framing_parser.sv
// HTTP/1.1 request framing parser, top level.
// Depends on hrfp_pkg and the channel interfaces in hrfp_channels.sv.
//
// Takes one raw request byte per req_ transaction and emits method, path and
// body bytes on rsp_, then one status transaction (is_status, last) on the
// byte flagged end_of_message; the parser returns to its reset state after
// it. Every byte is parsed in the cycle it is accepted, and its results
// appear on rsp_ from the next cycle through a four-entry result queue, so
// one byte is taken per clock as long as the consumer keeps up. A byte can
// give two results (a held CR that turns out to be content plus the byte
// itself, or a last byte plus the status); req_ready is low while the queue
// holds more than two results, so the result port's one-per-cycle drain
// sets the pace of such bursts. Bytes passed before an error are tentative. The user
// writes max_message_bytes on csr_ only while no message is in progress; unenforced.
`default_nettype none

module http_request_framing_parser
   import hrfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hrfp_req_if.sink   req_if,
   hrfp_rsp_if.source rsp_if,
   hrfp_csr_if.sink   csr_if
);

   localparam int QDEPTH = 4;

   // ---------------------------------------------------------------
   // Per-byte helpers
   // ---------------------------------------------------------------
   function automatic logic [3:0] latch_err(input logic [3:0] cur, input logic [3:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   // One content byte of a line; prod is ten times the accumulator plus the byte's digit
   function automatic content_type content_step(input state_type s, input logic [7:0] b,
                                                input logic quiet,
                                                input logic [67:0] prod);
      content_type r;
      logic [7:0]  lb;
      logic        cl_hit;
      logic        te_hit;
      r.st      = s;
      r.emit    = 1'b0;
      r.kind    = KIND_METHOD;
      r.st.line_nz = 1'b1;
      lb     = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? b + CASE_OFFSET : b;
      cl_hit = s.name_match[0] && (s.name_idx == CL_LEN);
      te_hit = s.name_match[1] && (s.name_idx == TE_LEN);
      if (s.phase == PH_LINE) begin
         if (b == CH_SP) begin
            if (s.space_cnt != 2'd3) r.st.space_cnt = s.space_cnt + 2'd1;
         end else if (s.space_cnt < 2'd2) begin
            if (!quiet && (s.err == ST_OK)) begin
               r.emit = 1'b1;
               r.kind = (s.space_cnt == 2'd0) ? KIND_METHOD : KIND_PATH;
            end
         end else if (s.space_cnt == 2'd2) begin
            if ((s.ver_idx >= VER_LEN) || (b != ver_char(s.ver_idx))) r.st.ver_bad = 1'b1;
            if (s.ver_idx <= VER_LEN) r.st.ver_idx = s.ver_idx + 4'd1;
         end
      end else if (!s.colon_seen) begin
         // header name
         if (b == CH_COLON) begin
            r.st.colon_seen = 1'b1;
            r.st.name_match = {te_hit, cl_hit};
         end else begin
            if ((s.name_idx >= CL_LEN) || (lb != cl_char(s.name_idx)))
               r.st.name_match[0] = 1'b0;
            if ((s.name_idx >= TE_LEN) || (lb != te_char(s.name_idx)))
               r.st.name_match[1] = 1'b0;
            if (s.name_idx != NAME_IDX_MAX) r.st.name_idx = s.name_idx + 5'd1;
         end
      end else if (s.name_match[0]) begin
         // content-length value
         if ((b == CH_SP) || (b == CH_TAB)) begin
            if (s.trim == TRIM_DIGITS) r.st.trim = TRIM_TAIL;
         end else if ((b >= CH_DIGIT_0) && (b <= CH_DIGIT_9)) begin
            if (s.trim == TRIM_TAIL) r.st.value_bad = 1'b1;
            else r.st.trim = TRIM_DIGITS;
            if (|prod[67:64]) r.st.acc_ovf = 1'b1;
            else r.st.acc = prod[63:0];
         end else begin
            r.st.value_bad = 1'b1;
         end
      end
      return r;
   endfunction

   // CR LF seen: close the current line
   function automatic state_type line_end(input state_type s, input logic [16:0] max_bytes);
      state_type r;
      logic      too_big;
      logic      acc_big;
      r       = s;
      too_big = ({1'b0, s.byte_pos} > {2'b00, max_bytes}) ||
                (({2'b00, s.body_len} + {1'b0, s.byte_pos}) > {2'b00, max_bytes});
      acc_big = (|s.acc[63:17]) || (s.acc[16:0] > max_bytes);
      if (s.phase == PH_LINE) begin
         if (!s.line_nz) r.err = latch_err(s.err, ST_NO_LINE);
         else if (s.space_cnt != 2'd2) r.err = latch_err(s.err, ST_BAD_LINE);
         else if (s.ver_bad || (s.ver_idx != VER_LEN)) r.err = latch_err(s.err, ST_VERSION);
         r.phase = PH_HDR;
      end else if (!s.line_nz) begin
         r.term_seen = 1'b1;
         r.phase     = PH_BODY;
         if (s.length_seen) begin
            if (too_big) r.err = latch_err(s.err, ST_TOO_LARGE);
            r.body_rem = s.body_len;
         end
      end else if (!s.colon_seen) begin
         r.err = latch_err(s.err, ST_HEADER);
      end else if (s.name_match[0]) begin
         if (s.length_seen || (s.trim == TRIM_LEAD) || s.value_bad || s.acc_ovf)
            r.err = latch_err(s.err, ST_BAD_LENGTH);
         else if (acc_big)
            r.err = latch_err(s.err, ST_TOO_LARGE);
         else begin
            r.length_seen = 1'b1;
            r.body_len    = s.acc[16:0];
         end
      end else if (s.name_match[1]) begin
         r.err = latch_err(s.err, ST_FRAMING);
      end
      // start of next line
      r.line_nz    = 1'b0;
      r.colon_seen = 1'b0;
      r.name_idx   = 5'd0;
      r.name_match = 2'b11;
      r.trim       = TRIM_LEAD;
      r.value_bad  = 1'b0;
      r.acc        = 64'd0;
      r.acc_ovf    = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [16:0]   max_ff;
   rsp_item_type  q_ff [QDEPTH];
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    count_ff, count_in;

   // Step signals
   logic          req_accept;
   logic          rsp_pop;
   logic [7:0]    b;
   logic          eom;
   logic          is_body;
   logic          quiet;
   logic          use_first;
   logic          use_second;
   logic          do_line_end;
   logic          body_emit;
   logic [7:0]    first_b;
   logic [67:0]   digit_prod;
   state_type     s1, s2;
   content_type   c1, c2;
   logic          a_v, b_v;
   rsp_item_type  item_a, item_b, item_c;
   rsp_item_type  r0, r1;
   logic [1:0]    n_push;
   logic [3:0]    status;

   assign b   = req_if.in_byte;
   assign eom = req_if.end_of_message;

   // Handshakes
   assign req_if.ready = (count_ff <= 3'(QDEPTH - 2));
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_if.valid = (count_ff != 3'd0);
   assign rsp_pop      = rsp_if.valid && rsp_if.ready;
   assign csr_if.ready = 1'b1;

   // Parse one byte
   always_comb begin
      s1 = state_ff;
      if (state_ff.byte_pos != POS_MAX) s1.byte_pos = state_ff.byte_pos + 18'd1;

      is_body     = (state_ff.phase == PH_BODY);
      quiet       = eom && (state_ff.phase == PH_LINE);
      do_line_end = !is_body && state_ff.pend_cr && (b == CH_LF);
      use_first   = !is_body && (state_ff.pend_cr ? (b != CH_LF) : (b != CH_CR));
      use_second  = !is_body && state_ff.pend_cr && (b != CH_LF) && (b != CH_CR);
      first_b     = state_ff.pend_cr ? CH_CR : b;
      body_emit   = is_body && (state_ff.err == ST_OK) && (state_ff.body_rem != 17'd0);

      // a held CR never touches the accumulator, so one product serves both bytes
      digit_prod = ({4'd0, state_ff.acc} << 3) + ({4'd0, state_ff.acc} << 1) +
                   {64'd0, b[3:0]};
      c1 = content_step(s1, first_b, quiet, digit_prod);
      c2 = content_step(c1.st, b, quiet, digit_prod);

      if (is_body) begin
         s2 = s1;
         if (body_emit) s2.body_rem = s1.body_rem - 17'd1;
      end else if (do_line_end) begin
         s2 = line_end(s1, max_ff);
      end else if (use_second) begin
         s2 = c2.st;
      end else if (use_first) begin
         s2 = c1.st;
      end else begin
         s2 = s1;
      end
      if (!is_body) s2.pend_cr = (b == CH_CR);

      // final status
      if (!s2.term_seen) status = ST_NO_TERM;
      else if (s2.err != ST_OK) status = s2.err;
      else if (s2.body_rem != 17'd0) status = ST_INCOMPLETE;
      else status = ST_OK;

      // candidate results in order
      a_v    = body_emit || (use_first && c1.emit);
      b_v    = use_second && c2.emit;
      item_a = '{out_byte: (is_body ? b : first_b), byte_kind: (is_body ? KIND_BODY : c1.kind),
                 is_status: 1'b0, status_code: ST_OK, last: 1'b0};
      item_b = '{out_byte: b, byte_kind: c2.kind, is_status: 1'b0, status_code: ST_OK,
                 last: 1'b0};
      item_c = '{out_byte: 8'h00, byte_kind: KIND_METHOD, is_status: 1'b1,
                 status_code: status, last: 1'b1};
      r0     = a_v ? item_a : (b_v ? item_b : item_c);
      r1     = (a_v && b_v) ? item_b : item_c;
      n_push = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, eom});

      state_in = state_ff;
      if (req_accept) state_in = eom ? STATE_RESET : s2;
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) wr_ptr_in = wr_ptr_ff + n_push;
      if (rsp_pop) rd_ptr_in = rd_ptr_ff + 2'd1;
      count_in = count_ff + (req_accept ? {1'b0, n_push} : 3'd0) - {2'b00, rsp_pop};
   end

   // Control state and register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= STATE_RESET;
         max_ff    <= MAX_MESSAGE_RESET;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (csr_if.valid) max_ff <= csr_if.max_message_bytes;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (req_accept && (n_push != 2'd0)) q_ff[wr_ptr_ff] <= r0;
      if (req_accept && (n_push == 2'd2)) q_ff[wr_ptr_ff + 2'd1] <= r1;
   end

   assign rsp_if.out_byte    = q_ff[rd_ptr_ff].out_byte;
   assign rsp_if.byte_kind   = q_ff[rd_ptr_ff].byte_kind;
   assign rsp_if.is_status   = q_ff[rd_ptr_ff].is_status;
   assign rsp_if.status_code = q_ff[rd_ptr_ff].status_code;
   assign rsp_if.last        = q_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

>>> sv/hrfp_checker.sv
// Port-level checks for the HTTP request framing parser, bound to the top.
// Depends on hrfp_pkg; attached by the bind statement at the end.
`default_nettype none

module hrfp_checker
   import hrfp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_eom,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_byte_kind,
   input logic       rsp_is_status,
   input logic [3:0] rsp_status_code,
   input logic       rsp_last
);

   // A closing byte always leaves a result transaction waiting
   a_eom_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_eom) |=> rsp_valid)
      else $error("no result after end of message");

   // Status transaction has a clean shape
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_status) |->
         (rsp_last && (rsp_out_byte == 8'h00) && (rsp_byte_kind == KIND_METHOD) &&
          (rsp_status_code <= ST_INCOMPLETE)))
      else $error("malformed status transaction");

   // Byte transaction carries no status
   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_status) |->
         (!rsp_last && (rsp_status_code == ST_OK) && (rsp_byte_kind != 2'd3)))
      else $error("malformed byte transaction");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_kind) &&
          $stable(rsp_is_status) && $stable(rsp_status_code)))
      else $error("result changed while stalled");

endmodule

bind http_request_framing_parser hrfp_checker u_hrfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_eom         (req_if.end_of_message),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_out_byte    (rsp_if.out_byte),
   .rsp_byte_kind   (rsp_if.byte_kind),
   .rsp_is_status   (rsp_if.is_status),
   .rsp_status_code (rsp_if.status_code),
   .rsp_last        (rsp_if.last)
);

`default_nettype wire

>>> test/http_request_framing_parser_checker.sv
`timescale 1ns / 100ps
// Checker for the HTTP request framing parser: follows the parse of every accepted
// request byte and compares each result transaction with the predicted one.
// Depends on hrfp_pkg and the channel interfaces in hrfp_channels.sv.
module http_request_framing_parser_checker
   import hrfp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hrfp_req_if  req_if,
   hrfp_rsp_if  rsp_if,
   hrfp_csr_if  csr_if,
   output int   fail_count,
   output int   backlog
);

   // Predicted parser state
   phase_type   phase;
   logic        cr_held;
   logic [16:0] line_bytes;
   logic [1:0]  spaces;
   logic [3:0]  ver_pos;
   logic        ver_wrong;
   logic [4:0]  name_pos;
   logic [1:0]  name_hits;    // bit 0 content-length, bit 1 transfer-encoding
   logic        colon;
   logic [1:0]  trim;
   logic        value_bad;
   logic [63:0] digits;
   logic        digits_ovf;
   logic        length_known;
   logic [16:0] body_len;
   logic [17:0] msg_pos;
   logic [16:0] body_left;
   logic        saw_blank;
   logic [3:0]  first_err;
   logic [16:0] limit_bytes;

   rsp_item_type pending_results[$];
   rsp_item_type want;
   int           mismatches;

   string cl_text  = "content-length";
   string te_text  = "transfer-encoding";
   string ver_text = "HTTP/1.1";

   task automatic expect_result(input logic [7:0] b, input logic [1:0] kind,
                                input logic status, input logic [3:0] code);
      rsp_item_type item;
      item = '{out_byte: b, byte_kind: kind, is_status: status,
               status_code: code, last: status};
      pending_results.insert(pending_results.size(), item);
   endtask

   // only the first error of a message counts
   task automatic note_error(input logic [3:0] code);
      if (first_err == ST_OK) first_err = code;
   endtask

   task automatic clear_line();
      line_bytes = '0;
      colon      = 1'b0;
      name_pos   = '0;
      name_hits  = 2'b11;
      trim       = TRIM_LEAD;
      value_bad  = 1'b0;
      digits     = '0;
      digits_ovf = 1'b0;
   endtask

   task automatic clear_parser();
      phase        = PH_LINE;
      cr_held      = 1'b0;
      spaces       = '0;
      ver_pos      = '0;
      ver_wrong    = 1'b0;
      length_known = 1'b0;
      body_len     = '0;
      msg_pos      = '0;
      body_left    = '0;
      saw_blank    = 1'b0;
      first_err    = ST_OK;
      clear_line();
   endtask

   // One content byte of the request line or of a header line
   task automatic take_content(input logic [7:0] b, input logic quiet);
      logic [7:0]  lower;
      logic [63:0] d;
      if (line_bytes != 17'h1FFFF) line_bytes++;
      if (phase == PH_LINE) begin
         if (b == CH_SP) begin
            if (spaces != 2'd3) spaces++;
         end else if (spaces < 2'd2) begin
            if (!quiet && first_err == ST_OK)
               expect_result(b, (spaces == 2'd0) ? KIND_METHOD : KIND_PATH, 1'b0, ST_OK);
         end else if (spaces == 2'd2) begin
            if (ver_pos >= VER_LEN || b != ver_text[ver_pos]) ver_wrong = 1'b1;
            if (ver_pos <= VER_LEN) ver_pos++;
         end
      end else if (!colon) begin
         if (b == CH_COLON) begin
            colon     = 1'b1;
            name_hits = {name_hits[1] && name_pos == TE_LEN,
                         name_hits[0] && name_pos == CL_LEN};
         end else begin
            lower = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
            if (name_pos >= CL_LEN || lower != cl_text[name_pos]) name_hits[0] = 1'b0;
            if (name_pos >= TE_LEN || lower != te_text[name_pos]) name_hits[1] = 1'b0;
            if (name_pos != NAME_IDX_MAX) name_pos++;
         end
      end else if (name_hits[0]) begin
         // content-length value: blanks, digits, blanks
         if (b == CH_SP || b == CH_TAB) begin
            if (trim == TRIM_DIGITS) trim = TRIM_TAIL;
         end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
            d = 64'(b - CH_DIGIT_0);
            if (trim == TRIM_TAIL) value_bad = 1'b1;
            else trim = TRIM_DIGITS;
            if (digits > (~64'd0 - d) / 64'd10) digits_ovf = 1'b1;
            else digits = digits * 64'd10 + d;
         end else begin
            value_bad = 1'b1;
         end
      end
   endtask

   // Works out the results of one accepted request byte
   task automatic parse_byte(input logic [7:0] b, input logic eom);
      logic       quiet;
      logic [3:0] code;
      quiet = eom && phase == PH_LINE;
      if (msg_pos != POS_MAX) msg_pos++;
      if (phase == PH_BODY) begin
         if (first_err == ST_OK && body_left != 0) begin
            expect_result(b, KIND_BODY, 1'b0, ST_OK);
            body_left--;
         end
      end else if (cr_held) begin
         cr_held = 1'b0;
         if (b == CH_LF) begin
            // end of line
            if (phase == PH_LINE) begin
               if (line_bytes == 0) note_error(ST_NO_LINE);
               else if (spaces != 2'd2) note_error(ST_BAD_LINE);
               else if (ver_wrong || ver_pos != VER_LEN) note_error(ST_VERSION);
               phase = PH_HDR;
            end else if (line_bytes == 0) begin
               saw_blank = 1'b1;
               phase     = PH_BODY;
               if (length_known) begin
                  if (msg_pos > {1'b0, limit_bytes} ||
                      {1'b0, body_len} > {1'b0, limit_bytes} - msg_pos)
                     note_error(ST_TOO_LARGE);
                  body_left = body_len;
               end
            end else if (!colon) begin
               note_error(ST_HEADER);
            end else if (name_hits[0]) begin
               if (length_known || trim == TRIM_LEAD || value_bad || digits_ovf)
                  note_error(ST_BAD_LENGTH);
               else if (digits > {47'd0, limit_bytes})
                  note_error(ST_TOO_LARGE);
               else begin
                  length_known = 1'b1;
                  body_len     = digits[16:0];
               end
            end else if (name_hits[1]) begin
               note_error(ST_FRAMING);
            end
            clear_line();
         end else begin
            // held CR was content after all
            take_content(CH_CR, quiet);
            if (b == CH_CR) cr_held = 1'b1;
            else take_content(b, quiet);
         end
      end else if (b == CH_CR) begin
         cr_held = 1'b1;
      end else begin
         take_content(b, quiet);
      end

      // final status, a missing terminator first
      if (eom) begin
         if (!saw_blank) code = ST_NO_TERM;
         else if (first_err != ST_OK) code = first_err;
         else if (body_left != 0) code = ST_INCOMPLETE;
         else code = ST_OK;
         expect_result(8'h00, KIND_METHOD, 1'b1, code);
         clear_parser();
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endtask

   // Results first: a byte accepted at this edge cannot have a result yet
   always @(posedge clock) begin
      if (reset) begin
         limit_bytes = MAX_MESSAGE_RESET;
         clear_parser();
         pending_results.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected: byte %0d status %0d",
                      rsp_if.out_byte, rsp_if.status_code);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_if.out_byte);
               check_field("byte_kind", want.byte_kind, rsp_if.byte_kind);
               check_field("is_status", want.is_status, rsp_if.is_status);
               check_field("status_code", want.status_code, rsp_if.status_code);
               check_field("last", want.last, rsp_if.last);
            end
         end
         if (csr_if.valid && csr_if.ready) limit_bytes = csr_if.max_message_bytes;
         if (req_if.valid && req_if.ready) parse_byte(req_if.in_byte, req_if.end_of_message);
      end
      fail_count <= mismatches;
      backlog    <= pending_results.size();
   end

endmodule

>>> test/http_request_framing_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the HTTP request framing parser: clock, reset, request messages,
// size-limit writes and result back-pressure; the verdict comes from the checker.
// Depends on hrfp_pkg, the channel interfaces and http_request_framing_parser_checker.
module http_request_framing_parser_tb;
   import hrfp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrfp_req_if req_if();
   hrfp_rsp_if rsp_if();
   hrfp_csr_if csr_if();

   int fail_count;
   int backlog;

   logic [7:0] msg_bytes[$];
   int         sent_bytes;
   bit         tail_phase;
   bit         long_hold_req;

   always #5 clock = ~clock;

   http_request_framing_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   http_request_framing_parser_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   function automatic logic [7:0] path_byte(input bit tidy);
      if (!tidy && $urandom_range(0, 11) == 0) return 8'($urandom);
      return 8'($urandom_range(33, 126));
   endfunction

   // appends one byte to the message
   task automatic add_byte(input logic [7:0] v);
      msg_bytes.insert(msg_bytes.size(), v);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // header name with letters in random case
   task automatic add_name(input string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - CASE_OFFSET;
         add_byte(c);
      end
   endtask

   // Builds one request; a non-negative forced_len gives a tidy one with that content-length
   task automatic build_request(input int forced_len);
      int    clen, body_n, value;
      bit    tidy, got_len;
      string name;
      tidy    = forced_len >= 0;
      got_len = 1'b0;
      clen    = 0;
      msg_bytes.delete();

      // raw noise now and then
      if (!tidy && $urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
         return;
      end

      // request line, now and then left out
      if (tidy || $urandom_range(0, 29) != 0) begin
         repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(65, 90)));
         add_byte(CH_SP);
         add_byte("/");
         repeat ($urandom_range(0, 8)) add_byte(path_byte(tidy));
         if (!tidy && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: add_byte(CH_CR);
               1: add_byte(CH_LF);
               default: add_text("\r\r");
            endcase
            add_byte(path_byte(1'b1));
         end
         repeat ((!tidy && $urandom_range(0, 11) == 0) ? $urandom_range(2, 4) : 1)
            add_byte(CH_SP);
         add_text("HTTP/1.1");
         if (!tidy && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: msg_bytes[msg_bytes.size() - 1 - $urandom_range(0, 7)] =
                     8'($urandom_range(33, 126));
               1: msg_bytes.delete(msg_bytes.size() - 1);
               default: add_byte("1");
            endcase
         end
      end
      add_text("\r\n");

      // header lines
      repeat (tidy ? 1 : $urandom_range(0, 4)) begin
         case (tidy ? 0 : $urandom_range(0, 11))
            0, 1, 2: begin
               add_name("content-length");
               add_byte(CH_COLON);
               repeat ($urandom_range(0, 2))
                  add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
               case (tidy ? 0 : $urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5, 6: begin
                     if (tidy) value = forced_len;
                     else if ($urandom_range(0, 7) == 0) value = $urandom_range(13, 70000);
                     else value = $urandom_range(0, 12);
                     add_text($sformatf("%0d", value));
                     if (!got_len) begin
                        got_len = 1'b1;
                        clen    = value;
                     end
                  end
                  7: begin
                     case ($urandom_range(0, 2))
                        0: add_text("18446744073709551615");
                        1: add_text("18446744073709551616");
                        default: add_text("99999999999999999999999");
                     endcase
                  end
                  8: ;
                  default: begin
                     if ($urandom_range(0, 1)) add_text("4 2");
                     else add_text("7a");
                  end
               endcase
               repeat ($urandom_range(0, 2))
                  add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
            end
            3: begin
               add_name("transfer-encoding");
               add_text(": chunked");
            end
            4: repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(97, 122)));
            5: begin
               // near misses of the length header name
               name = "content-length";
               if ($urandom_range(0, 1)) add_name(name.substr(0, $urandom_range(0, 12)));
               else add_name("content-lengths");
               add_text(": 5");
            end
            6: begin
               repeat ($urandom_range(32, 40))
                  add_byte(8'($urandom_range(97, 122)));
               add_text(": 3");
            end
            default: begin
               repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(97, 122)));
               add_byte(CH_COLON);
               repeat ($urandom_range(0, 10)) add_byte(path_byte(1'b0));
            end
         endcase
         add_text("\r\n");
      end

      // blank line (now and then left out), then the body, sometimes short or with spare bytes
      if (tidy || $urandom_range(0, 14) != 0) add_text("\r\n");
      body_n = (clen > 16) ? $urandom_range(0, 16) : clen;
      if (!tidy && $urandom_range(0, 7) == 0) body_n += $urandom_range(1, 5);
      else if (!tidy && body_n > 0 && $urandom_range(0, 7) == 0) body_n--;
      repeat (body_n) add_byte(8'($urandom));
   endtask

   // Offers the message byte by byte; valid stays up after the last transaction
   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++) begin
         req_if.valid          <= 1'b1;
         req_if.in_byte        <= msg_bytes[i];
         req_if.end_of_message <= (i == msg_bytes.size() - 1);
         do @(posedge clock); while (req_if.ready !== 1'b1);
         sent_bytes++;
         if (!tail_phase && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   // size limit written only with the parser idle
   task automatic write_limit(input logic [16:0] v);
      drain();
      repeat (4) @(posedge clock);
      csr_if.valid             <= 1'b1;
      csr_if.max_message_bytes <= v;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_random(input int upto);
      while (sent_bytes < upto) begin
         if (sent_bytes >= 560) tail_phase = 1'b1;
         build_request(-1);
         send_message();
      end
   endtask

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      req_if.valid             <= 1'b0;
      req_if.in_byte           <= 8'h00;
      req_if.end_of_message    <= 1'b0;
      csr_if.valid             <= 1'b0;
      csr_if.max_message_bytes <= MAX_MESSAGE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // lone byte ending the message in the request line
      msg_bytes = '{8'h00};
      send_message();
      // blank request line
      msg_bytes.delete();
      add_text("\r\n\r\n");
      send_message();
      // top byte value as the method
      msg_bytes = '{8'hFF};
      add_text(" B HTTP/1.1\r\n\r\n");
      send_message();

      // tidy request with content-length 60 against a stalled result side
      long_hold_req = 1'b1;
      build_request(60);
      send_message();

      run_random(170);
      write_limit(17'd1);
      run_random(260);
      write_limit(17'($urandom_range(24, 120)));
      run_random(400);
      write_limit(17'h0FFFF);
      run_random(480);
      write_limit(MAX_MESSAGE_RESET);
      run_random(700);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
